>>> rtl/core/packet_traffic_stat_tables_unit_assert.svh
// Assertion macros for the traffic statistics unit.
`ifndef PACKET_TRAFFIC_STAT_TABLES_UNIT_ASSERT_SVH
`define PACKET_TRAFFIC_STAT_TABLES_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define PTST_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("ptst check failed");

// Check a condition in the cycle after its trigger.
`define PTST_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("ptst check failed");

`endif

>>> rtl/core/ptst_pkg.sv
// Shared types and constants for the traffic statistics unit.
package ptst_pkg;

  localparam int MAC_ENTRIES  = 256;
  localparam int IP_ENTRIES   = 256;
  localparam int FLOW_ENTRIES = 512;
  localparam int TOTAL_ENTRIES = MAC_ENTRIES + IP_ENTRIES + FLOW_ENTRIES;
  localparam int AW  = $clog2(TOTAL_ENTRIES);
  localparam int MUW = $clog2(MAC_ENTRIES + 1);
  localparam int IUW = $clog2(IP_ENTRIES + 1);
  localparam int FUW = $clog2(FLOW_ENTRIES + 1);
  localparam int CW  = (MUW > IUW) ? ((MUW > FUW) ? MUW : FUW) : ((IUW > FUW) ? IUW : FUW);

  localparam logic [AW-1:0] MAC_BASE  = AW'(0);
  localparam logic [AW-1:0] IP_BASE   = AW'(MAC_ENTRIES);
  localparam logic [AW-1:0] FLOW_BASE = AW'(MAC_ENTRIES + IP_ENTRIES);

  // key: {udp, port_a, port_b, addr_a, addr_b} for flows, low bits otherwise
  localparam int KW  = 97;
  // counters: {rx_bytes, tx_bytes, rx_packets, tx_packets}
  localparam int CTW = 192;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [1:0] TBL_MAC  = 2'd0;
  localparam logic [1:0] TBL_IP   = 2'd1;
  localparam logic [1:0] TBL_FLOW = 2'd2;

  localparam logic [1:0] STAT_COUNTED = 2'd0;
  localparam logic [1:0] STAT_IGNORED = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_READ    = 2'd3;

  localparam logic CMD_COUNT = 1'b0;

  localparam logic [2:0] UPD_FLOW_FIRST = 3'd4;
  localparam logic [2:0] UPD_COUNT      = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_UPD,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic dir;   // 0 send side, 1 receive side
    logic wide;  // 64-bit byte counters
  } alu_ctl_t;

endpackage

>>> rtl/core/ptst_ram.sv
// Simple dual-port RAM with registered read data.
module ptst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ptst_alu.sv
// Shared key compare and counter update unit.
module ptst_alu (
  input  ptst_pkg::alu_ctl_t          ctl,
  input  logic [ptst_pkg::KW-1:0]     key_a,
  input  logic [ptst_pkg::KW-1:0]     key_b,
  input  logic [ptst_pkg::CTW-1:0]    old_ctr,
  input  logic [15:0]                 len,
  output logic                        key_eq,
  output logic [ptst_pkg::CTW-1:0]    new_ctr
);

  logic [31:0] tx_pk, rx_pk;
  logic [63:0] tx_by, rx_by, sel_by, sum_by;

  assign key_eq = (key_a == key_b);

  always_comb begin
    tx_pk  = old_ctr[31:0];
    rx_pk  = old_ctr[63:32];
    tx_by  = old_ctr[127:64];
    rx_by  = old_ctr[191:128];
    sel_by = ctl.dir ? rx_by : tx_by;
    sum_by = sel_by + {48'd0, len};
    if (!ctl.wide) begin
      sum_by = {32'd0, sum_by[31:0]};
    end
    if (ctl.dir) begin
      rx_pk = rx_pk + 32'd1;
      rx_by = sum_by;
    end else begin
      tx_pk = tx_pk + 32'd1;
      tx_by = sum_by;
    end
    new_ctr = {rx_by, tx_by, rx_pk, tx_pk};
  end

endmodule

>>> rtl/core/packet_traffic_stat_tables_unit.sv
// Top level of the traffic statistics unit: sequencer, tables and result register.
//
// channel  | valid         | stall         | payload
// item     | item_valid    | item_stall    | command .. entry_index
// result   | result_valid  | result_stall  | status .. rx_bytes
//
// An IPv4 count beat runs four or six updates; any other count beat runs none.
// Each update scans its table by linear search (key read, compare per entry
// in use), then writes the counters; an absent key is first appended. A read
// beat passes RD_ISSUE and RD_DATA. The single key memory port sets the pace.
// Reset (synchronous, active high) empties all tables at once via the fill
// counts; no clearing pass. The next beat is taken while a result still
// waits under result_stall; the sequencer then holds in its final state.
`include "packet_traffic_stat_tables_unit_assert.svh"

module packet_traffic_stat_tables_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  logic         command,
  input  logic [15:0]  eth_type,
  input  logic [47:0]  src_mac,
  input  logic [47:0]  dst_mac,
  input  logic [31:0]  src_ip,
  input  logic [31:0]  dst_ip,
  input  logic [7:0]   ip_protocol,
  input  logic [15:0]  src_port,
  input  logic [15:0]  dst_port,
  input  logic [15:0]  frame_length,
  input  logic [1:0]   table_select,
  input  logic [8:0]   entry_index,
  output logic         result_valid,
  input  logic         result_stall,
  output logic [1:0]   status,
  output logic         entry_valid,
  output logic [47:0]  key_addr_a,
  output logic [31:0]  key_addr_b,
  output logic [15:0]  key_port_a,
  output logic [15:0]  key_port_b,
  output logic         key_is_udp,
  output logic [31:0]  tx_packets,
  output logic [31:0]  rx_packets,
  output logic [63:0]  tx_bytes,
  output logic [63:0]  rx_bytes
);

  localparam int AW  = ptst_pkg::AW;
  localparam int CW  = ptst_pkg::CW;
  localparam int KW  = ptst_pkg::KW;
  localparam int CTW = ptst_pkg::CTW;

  ptst_pkg::state_t state, state_next;

  // latched beat
  logic        cmd, is_l4, is_udp;
  logic [1:0]  sel;
  logic [8:0]  idx;
  logic [47:0] smac, dmac;
  logic [31:0] sip, dip;
  logic [15:0] sport, dport, len;

  // sequencer state
  logic [2:0]     upd;
  logic [CW-1:0]  scan_idx;
  logic [CW-1:0]  slot;
  logic           fresh;
  logic           full;
  logic [1:0]     status_code;
  logic           rd_hit;
  logic [KW-1:0]  rd_key;
  logic [CTW-1:0] rd_ctr;

  // fill counts
  logic [ptst_pkg::MUW-1:0] mac_used;
  logic [ptst_pkg::IUW-1:0] ip_used;
  logic [ptst_pkg::FUW-1:0] flow_used;

  // memory ports
  logic           key_we, ctr_we;
  logic [AW-1:0]  key_waddr, key_raddr, ctr_waddr, ctr_raddr;
  logic [KW-1:0]  key_rdata;
  logic [CTW-1:0] ctr_rdata, ctr_new, ctr_old;

  logic [1:0]     tbl;
  logic [KW-1:0]  key_cur;
  logic [CW-1:0]  cur_used, cur_cap;
  logic [AW-1:0]  cur_base, rd_base;
  logic           upd_done, key_eq, rd_ok, out_free, accept;
  logic           in_table, tbl_full, fill_ok;
  ptst_pkg::alu_ctl_t alu_ctl;

  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign item_stall = (state != ptst_pkg::ST_IDLE);

  assign tbl = upd[2:1];
  assign upd_done = (upd == ptst_pkg::UPD_COUNT) ||
                    (upd == ptst_pkg::UPD_FLOW_FIRST && !is_l4);
  assign in_table = (scan_idx < cur_used);
  assign tbl_full = (cur_used >= cur_cap);

  // Pick the key, fill count and region of the running update.
  always_comb begin
    case (upd)
      3'd0:    key_cur = {49'd0, smac};
      3'd1:    key_cur = {49'd0, dmac};
      3'd2:    key_cur = {65'd0, sip};
      3'd3:    key_cur = {65'd0, dip};
      3'd4:    key_cur = {is_udp, sport, dport, sip, dip};
      default: key_cur = {is_udp, dport, sport, dip, sip};
    endcase
    case (tbl)
      ptst_pkg::TBL_MAC: begin
        cur_used = CW'(mac_used);
        cur_cap  = CW'(ptst_pkg::MAC_ENTRIES);
        cur_base = ptst_pkg::MAC_BASE;
      end
      ptst_pkg::TBL_IP: begin
        cur_used = CW'(ip_used);
        cur_cap  = CW'(ptst_pkg::IP_ENTRIES);
        cur_base = ptst_pkg::IP_BASE;
      end
      default: begin
        cur_used = CW'(flow_used);
        cur_cap  = CW'(ptst_pkg::FLOW_ENTRIES);
        cur_base = ptst_pkg::FLOW_BASE;
      end
    endcase
  end

  // Read beat: entry must lie below the fill count of its table.
  always_comb begin
    case (sel)
      ptst_pkg::TBL_MAC: begin
        rd_ok   = (CW'(idx) < CW'(mac_used));
        rd_base = ptst_pkg::MAC_BASE;
      end
      ptst_pkg::TBL_IP: begin
        rd_ok   = (CW'(idx) < CW'(ip_used));
        rd_base = ptst_pkg::IP_BASE;
      end
      ptst_pkg::TBL_FLOW: begin
        rd_ok   = (CW'(idx) < CW'(flow_used));
        rd_base = ptst_pkg::FLOW_BASE;
      end
      default: begin
        rd_ok   = 1'b0;
        rd_base = ptst_pkg::MAC_BASE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ptst_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (command != ptst_pkg::CMD_COUNT) begin
            state_next = ptst_pkg::ST_RD_ISSUE;
          end else if (eth_type == ptst_pkg::ETHERTYPE_IPV4) begin
            state_next = ptst_pkg::ST_SCAN;
          end else begin
            state_next = ptst_pkg::ST_DONE;
          end
        end
      end
      ptst_pkg::ST_SCAN: begin
        if (upd_done) begin
          state_next = ptst_pkg::ST_DONE;
        end else if (in_table) begin
          state_next = ptst_pkg::ST_CMP;
        end else if (!tbl_full) begin
          state_next = ptst_pkg::ST_UPD;
        end
      end
      ptst_pkg::ST_CMP:      state_next = key_eq ? ptst_pkg::ST_UPD : ptst_pkg::ST_SCAN;
      ptst_pkg::ST_UPD:      state_next = ptst_pkg::ST_SCAN;
      ptst_pkg::ST_RD_ISSUE: state_next = ptst_pkg::ST_RD_DATA;
      ptst_pkg::ST_RD_DATA:  state_next = ptst_pkg::ST_DONE;
      ptst_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ptst_pkg::ST_IDLE;
        end
      end
      default: state_next = ptst_pkg::ST_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    key_we    = 1'b0;
    ctr_we    = 1'b0;
    key_waddr = cur_base + AW'(cur_used);
    ctr_waddr = cur_base + AW'(slot);
    key_raddr = cur_base + AW'(scan_idx);
    ctr_raddr = cur_base + AW'(scan_idx);
    case (state)
      ptst_pkg::ST_SCAN: begin
        key_we = !upd_done && !in_table && !tbl_full;
      end
      ptst_pkg::ST_UPD: begin
        ctr_we = 1'b1;
      end
      ptst_pkg::ST_RD_ISSUE: begin
        key_raddr = rd_base + AW'(idx);
        ctr_raddr = rd_base + AW'(idx);
      end
      default: begin
        key_we = 1'b0;
      end
    endcase
  end

  assign alu_ctl = '{dir: upd[0], wide: (tbl == ptst_pkg::TBL_MAC)};
  assign ctr_old = fresh ? '0 : ctr_rdata;

  ptst_ram #(.WIDTH(KW), .DEPTH(ptst_pkg::TOTAL_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_cur),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  ptst_ram #(.WIDTH(CTW), .DEPTH(ptst_pkg::TOTAL_ENTRIES)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_new),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  ptst_alu u_alu (
    .ctl     (alu_ctl),
    .key_a   (key_rdata),
    .key_b   (key_cur),
    .old_ctr (ctr_old),
    .len     (len),
    .key_eq  (key_eq),
    .new_ctr (ctr_new)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ptst_pkg::ST_IDLE;
      mac_used     <= '0;
      ip_used      <= '0;
      flow_used    <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ptst_pkg::ST_SCAN && key_we) begin
        case (tbl)
          ptst_pkg::TBL_MAC: mac_used  <= mac_used + 1'b1;
          ptst_pkg::TBL_IP:  ip_used   <= ip_used + 1'b1;
          default:           flow_used <= flow_used + 1'b1;
        endcase
      end
      if (state == ptst_pkg::ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      ptst_pkg::ST_IDLE: begin
        if (accept) begin
          cmd      <= command;
          sel      <= table_select;
          idx      <= entry_index;
          smac     <= src_mac;
          dmac     <= dst_mac;
          sip      <= src_ip;
          dip      <= dst_ip;
          sport    <= src_port;
          dport    <= dst_port;
          len      <= frame_length;
          is_l4    <= (ip_protocol == ptst_pkg::PROTO_TCP) ||
                      (ip_protocol == ptst_pkg::PROTO_UDP);
          is_udp   <= (ip_protocol == ptst_pkg::PROTO_UDP);
          upd      <= 3'd0;
          scan_idx <= '0;
          full     <= 1'b0;
          rd_hit   <= 1'b0;
          if (command != ptst_pkg::CMD_COUNT) begin
            status_code <= ptst_pkg::STAT_READ;
          end else if (eth_type == ptst_pkg::ETHERTYPE_IPV4) begin
            status_code <= ptst_pkg::STAT_COUNTED;
          end else begin
            status_code <= ptst_pkg::STAT_IGNORED;
          end
        end
      end
      ptst_pkg::ST_SCAN: begin
        if (upd_done) begin
          status_code <= full ? ptst_pkg::STAT_FULL : ptst_pkg::STAT_COUNTED;
        end else if (!in_table) begin
          if (tbl_full) begin
            // drop this update and move on
            full     <= 1'b1;
            upd      <= upd + 3'd1;
            scan_idx <= '0;
          end else begin
            slot  <= cur_used;
            fresh <= 1'b1;
          end
        end
      end
      ptst_pkg::ST_CMP: begin
        if (key_eq) begin
          slot  <= scan_idx;
          fresh <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      ptst_pkg::ST_UPD: begin
        upd      <= upd + 3'd1;
        scan_idx <= '0;
      end
      ptst_pkg::ST_RD_ISSUE: begin
        rd_hit <= rd_ok;
      end
      ptst_pkg::ST_RD_DATA: begin
        rd_key <= key_rdata;
        rd_ctr <= ctr_rdata;
      end
      default: begin
        fresh <= fresh;
      end
    endcase
  end

  // Result register: load the formatted beat when the slot is free.
  always_ff @(posedge clk) begin
    if (state == ptst_pkg::ST_DONE && out_free) begin
      status      <= status_code;
      entry_valid <= cmd && rd_hit;
      key_addr_a  <= '0;
      key_addr_b  <= '0;
      key_port_a  <= '0;
      key_port_b  <= '0;
      key_is_udp  <= 1'b0;
      tx_packets  <= '0;
      rx_packets  <= '0;
      tx_bytes    <= '0;
      rx_bytes    <= '0;
      if (cmd && rd_hit) begin
        tx_packets <= rd_ctr[31:0];
        rx_packets <= rd_ctr[63:32];
        tx_bytes   <= rd_ctr[127:64];
        rx_bytes   <= rd_ctr[191:128];
        case (sel)
          ptst_pkg::TBL_MAC: key_addr_a <= rd_key[47:0];
          ptst_pkg::TBL_IP:  key_addr_a <= {16'd0, rd_key[31:0]};
          default: begin
            key_addr_a <= {16'd0, rd_key[63:32]};
            key_addr_b <= rd_key[31:0];
            key_port_a <= rd_key[95:80];
            key_port_b <= rd_key[79:64];
            key_is_udp <= rd_key[96];
          end
        endcase
      end
    end
  end

  assign fill_ok = (CW'(mac_used) <= CW'(ptst_pkg::MAC_ENTRIES)) &&
                   (CW'(ip_used) <= CW'(ptst_pkg::IP_ENTRIES)) &&
                   (CW'(flow_used) <= CW'(ptst_pkg::FLOW_ENTRIES));

  `PTST_ASSERT_NEXT(a_result_loaded, state == ptst_pkg::ST_DONE && out_free, result_valid)
  `PTST_ASSERT_NOW(a_fill_bounds, 1'b1, fill_ok)
  `PTST_ASSERT_NEXT(a_busy_after_accept, accept, item_stall)

endmodule

>>> tb/packet_traffic_stat_tables_unit_tb.sv
// Testbench for the traffic statistics unit: directed and random beats against a local predictor.
`timescale 1ns / 1ps

module packet_traffic_stat_tables_unit_tb;

  // One input beat, one field per port.
  typedef struct packed {
    logic        cmd;
    logic [15:0] etype;
    logic [47:0] smac;
    logic [47:0] dmac;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] len;
    logic [1:0]  sel;
    logic [8:0]  idx;
  } pkt_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic        valid;
    logic [47:0] addr_a;
    logic [31:0] addr_b;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic        udp;
    logic [31:0] txp;
    logic [31:0] rxp;
    logic [63:0] txb;
    logic [63:0] rxb;
  } stat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic command = 1'b0;
  logic [15:0] eth_type = '0;
  logic [47:0] src_mac = '0;
  logic [47:0] dst_mac = '0;
  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [7:0]  ip_protocol = '0;
  logic [15:0] src_port = '0;
  logic [15:0] dst_port = '0;
  logic [15:0] frame_length = '0;
  logic [1:0]  table_select = '0;
  logic [8:0]  entry_index = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0]  status;
  logic        entry_valid;
  logic [47:0] key_addr_a;
  logic [31:0] key_addr_b;
  logic [15:0] key_port_a;
  logic [15:0] key_port_b;
  logic        key_is_udp;
  logic [31:0] tx_packets;
  logic [31:0] rx_packets;
  logic [63:0] tx_bytes;
  logic [63:0] rx_bytes;

  packet_traffic_stat_tables_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: keys and counters per table, in insertion order.
  logic [47:0] mac_key [ptst_pkg::MAC_ENTRIES];
  logic [31:0] mac_txp [ptst_pkg::MAC_ENTRIES];
  logic [31:0] mac_rxp [ptst_pkg::MAC_ENTRIES];
  logic [63:0] mac_txb [ptst_pkg::MAC_ENTRIES];
  logic [63:0] mac_rxb [ptst_pkg::MAC_ENTRIES];
  int          mac_fill;
  logic [31:0] ip_key [ptst_pkg::IP_ENTRIES];
  logic [31:0] ip_ctr [ptst_pkg::IP_ENTRIES][4];
  int          ip_fill;
  logic [96:0] flow_key [ptst_pkg::FLOW_ENTRIES];
  logic [31:0] flow_ctr [ptst_pkg::FLOW_ENTRIES][4];
  int          flow_fill;

  stat_t expected_stats[$];
  int    errors = 0;
  int    cycles = 0;
  bit    long_stalls = 1'b1;
  bit    sender_gaps = 1'b1;

  // Return 1 when the update was dropped because the table is full.
  function automatic bit mac_bump(logic [47:0] k, bit rx, logic [15:0] n);
    int s;
    s = -1;
    for (int i = 0; i < mac_fill; i++) if (mac_key[i] == k && s < 0) s = i;
    if (s < 0) begin
      if (mac_fill >= ptst_pkg::MAC_ENTRIES) return 1'b1;
      s = mac_fill++;
      mac_key[s] = k;
      mac_txp[s] = '0; mac_rxp[s] = '0; mac_txb[s] = '0; mac_rxb[s] = '0;
    end
    if (rx) begin
      mac_rxp[s] += 1; mac_rxb[s] += n;
    end else begin
      mac_txp[s] += 1; mac_txb[s] += n;
    end
    return 1'b0;
  endfunction

  function automatic bit ip_bump(logic [31:0] k, bit rx, logic [15:0] n);
    int s;
    s = -1;
    for (int i = 0; i < ip_fill; i++) if (ip_key[i] == k && s < 0) s = i;
    if (s < 0) begin
      if (ip_fill >= ptst_pkg::IP_ENTRIES) return 1'b1;
      s = ip_fill++;
      ip_key[s] = k;
      for (int j = 0; j < 4; j++) ip_ctr[s][j] = '0;
    end
    ip_ctr[s][rx] += 1;
    ip_ctr[s][2 + rx] += n;
    return 1'b0;
  endfunction

  function automatic bit flow_bump(logic [96:0] k, bit rx, logic [15:0] n);
    int s;
    s = -1;
    for (int i = 0; i < flow_fill; i++) if (flow_key[i] == k && s < 0) s = i;
    if (s < 0) begin
      if (flow_fill >= ptst_pkg::FLOW_ENTRIES) return 1'b1;
      s = flow_fill++;
      flow_key[s] = k;
      for (int j = 0; j < 4; j++) flow_ctr[s][j] = '0;
    end
    flow_ctr[s][rx] += 1;
    flow_ctr[s][2 + rx] += n;
    return 1'b0;
  endfunction

  // Apply one beat to the predictor and return the result it should produce.
  function automatic stat_t count_or_read(pkt_t p);
    stat_t r;
    bit    full;
    logic  u;
    r = '{default: '0};
    if (p.cmd != ptst_pkg::CMD_COUNT) begin
      r.status = ptst_pkg::STAT_READ;
      if (p.sel == ptst_pkg::TBL_MAC && p.idx < mac_fill) begin
        r.valid = 1'b1; r.addr_a = mac_key[p.idx];
        r.txp = mac_txp[p.idx]; r.rxp = mac_rxp[p.idx];
        r.txb = mac_txb[p.idx]; r.rxb = mac_rxb[p.idx];
      end else if (p.sel == ptst_pkg::TBL_IP && p.idx < ip_fill) begin
        r.valid = 1'b1; r.addr_a = {16'h0, ip_key[p.idx]};
        r.txp = ip_ctr[p.idx][0]; r.rxp = ip_ctr[p.idx][1];
        r.txb = {32'h0, ip_ctr[p.idx][2]}; r.rxb = {32'h0, ip_ctr[p.idx][3]};
      end else if (p.sel == ptst_pkg::TBL_FLOW && p.idx < flow_fill) begin
        r.valid = 1'b1;
        {r.udp, r.port_a, r.port_b, r.addr_a[31:0], r.addr_b} = flow_key[p.idx];
        r.txp = flow_ctr[p.idx][0]; r.rxp = flow_ctr[p.idx][1];
        r.txb = {32'h0, flow_ctr[p.idx][2]}; r.rxb = {32'h0, flow_ctr[p.idx][3]};
      end
      return r;
    end
    if (p.etype != ptst_pkg::ETHERTYPE_IPV4) begin
      r.status = ptst_pkg::STAT_IGNORED;
      return r;
    end
    full = 1'b0;
    full |= mac_bump(p.smac, 1'b0, p.len);
    full |= mac_bump(p.dmac, 1'b1, p.len);
    full |= ip_bump(p.sip, 1'b0, p.len);
    full |= ip_bump(p.dip, 1'b1, p.len);
    if (p.proto == ptst_pkg::PROTO_TCP || p.proto == ptst_pkg::PROTO_UDP) begin
      u = (p.proto == ptst_pkg::PROTO_UDP);
      full |= flow_bump({u, p.sport, p.dport, p.sip, p.dip}, 1'b0, p.len);
      full |= flow_bump({u, p.dport, p.sport, p.dip, p.sip}, 1'b1, p.len);
    end
    r.status = full ? ptst_pkg::STAT_FULL : ptst_pkg::STAT_COUNTED;
    return r;
  endfunction

  // Gap length: mostly zero or short, now and then long.
  function automatic int gap_len(bit enabled);
    if (!enabled) return 0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 0;
      9:             return $urandom_range(40, 10);
      default:       return $urandom_range(3, 1);
    endcase
  endfunction

  // Drive one beat, hold it until accepted, then drop valid for a gap, if any.
  task automatic send_beat(pkt_t p);
    int g;
    expected_stats.push_back(count_or_read(p));
    item_valid   <= 1'b1;
    command      <= p.cmd;
    eth_type     <= p.etype;
    src_mac      <= p.smac;
    dst_mac      <= p.dmac;
    src_ip       <= p.sip;
    dst_ip       <= p.dip;
    ip_protocol  <= p.proto;
    src_port     <= p.sport;
    dst_port     <= p.dport;
    frame_length <= p.len;
    table_select <= p.sel;
    entry_index  <= p.idx;
    do @(posedge clk); while (item_stall);
    g = gap_len(sender_gaps);
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic idle_sender();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off until every expected result has come back.
  task automatic drain();
    idle_sender();
    while (expected_stats.size() > 0) @(posedge clk);
  endtask

  function automatic pkt_t rand_pkt();
    pkt_t p;
    p.cmd   = 1'b0;
    p.etype = ($urandom_range(7) == 0) ? 16'($urandom) : ptst_pkg::ETHERTYPE_IPV4;
    p.smac  = {16'($urandom), 32'($urandom)};
    p.dmac  = {16'($urandom), 32'($urandom)};
    p.sip   = $urandom;
    p.dip   = $urandom;
    case ($urandom_range(3))
      0:       p.proto = 8'($urandom);
      1:       p.proto = ptst_pkg::PROTO_UDP;
      default: p.proto = ptst_pkg::PROTO_TCP;
    endcase
    p.sport = 16'($urandom);
    p.dport = 16'($urandom);
    p.len   = 16'($urandom);
    p.sel   = 2'($urandom);
    p.idx   = 9'($urandom);
    return p;
  endfunction

  // Small host pool so that keys repeat and counters build up.
  function automatic pkt_t pool_pkt(int hosts);
    pkt_t p;
    int a, b;
    p = rand_pkt();
    p.etype = ptst_pkg::ETHERTYPE_IPV4;
    a = $urandom_range(hosts - 1);
    b = $urandom_range(hosts - 1);
    p.smac  = 48'hA0_0000_0000 + 48'(a);
    p.dmac  = 48'hA0_0000_0000 + 48'(b);
    p.sip   = 32'h0A00_0000 + 32'(a);
    p.dip   = 32'h0A00_0000 + 32'(b);
    p.proto = $urandom_range(1) ? ptst_pkg::PROTO_TCP : ptst_pkg::PROTO_UDP;
    p.sport = 16'd1000 + 16'($urandom_range(3));
    p.dport = 16'd80 + 16'($urandom_range(1));
    return p;
  endfunction

  function automatic pkt_t read_pkt(logic [1:0] sel, logic [8:0] idx);
    pkt_t p;
    p = rand_pkt();
    p.cmd = 1'b1;
    p.sel = sel;
    p.idx = idx;
    return p;
  endfunction

  // Directed: field extremes, both commands, every status but full, same-key packets.
  task automatic test_directed();
    pkt_t p;
    p = pool_pkt(4);
    p.smac = '1; p.dmac = '0; p.sip = '1; p.dip = '0;
    p.sport = '1; p.dport = '0; p.len = '1; p.proto = ptst_pkg::PROTO_TCP;
    send_beat(p);
    p.len = '0; p.proto = ptst_pkg::PROTO_UDP;
    send_beat(p);
    p.smac = 48'h12; p.dmac = 48'h12; p.sip = 32'h5; p.dip = 32'h5;
    p.sport = 16'd7; p.dport = 16'd7; p.len = 16'd64;
    send_beat(p);
    p.proto = 8'd1;
    send_beat(p);
    p.proto = '1;
    send_beat(p);
    p.etype = 16'h86DD;
    send_beat(p);
    p.etype = '1;
    send_beat(p);
    p.etype = '0;
    send_beat(p);
    for (int t = 0; t < 4; t++)
      for (int i = 0; i < 4; i++) send_beat(read_pkt(t[1:0], i[8:0]));
    send_beat(read_pkt(ptst_pkg::TBL_FLOW, '1));
    drain();
  endtask

  // Random traffic mixed with reads at indices up to the MAC fill count plus four.
  task automatic test_random_traffic(int beats);
    pkt_t p;
    for (int n = 0; n < beats; n++) begin
      case ($urandom_range(9))
        0, 1, 2: p = read_pkt(2'($urandom), 9'($urandom_range(mac_fill + 4)));
        3:       p = rand_pkt();
        default: p = pool_pkt(12);
      endcase
      send_beat(p);
    end
    drain();
  endtask

  // Back-to-back beats with the result side never stalling.
  task automatic test_streaming(int beats);
    long_stalls = 1'b0;
    sender_gaps = 1'b0;
    for (int n = 0; n < beats; n++)
      send_beat(($urandom_range(2) == 0) ?
                read_pkt(2'($urandom_range(2)), 9'($urandom_range(15))) : pool_pkt(6));
    drain();
    long_stalls = 1'b1;
    sender_gaps = 1'b1;
  endtask

  // Fill the MAC and IP tables to overflow so the full status shows up.
  task automatic test_table_full();
    pkt_t p;
    sender_gaps = 1'b0;
    for (int n = 0; n < 140; n++) begin
      p = rand_pkt();
      p.etype = ptst_pkg::ETHERTYPE_IPV4;
      p.proto = 8'd1;
      send_beat(p);
    end
    for (int n = 0; n < 20; n++) begin
      p = rand_pkt();
      p.etype = ptst_pkg::ETHERTYPE_IPV4;
      send_beat(p);
    end
    sender_gaps = 1'b1;
    for (int n = 0; n < 12; n++)
      send_beat(read_pkt(2'($urandom_range(2)), 9'(ptst_pkg::MAC_ENTRIES - 6 + n)));
    send_beat(read_pkt(ptst_pkg::TBL_MAC, 9'(ptst_pkg::MAC_ENTRIES)));
    drain();
  endtask

  // Result side stall: random gaps, long ones sometimes.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      result_stall <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      g = gap_len(long_stalls);
      if (g > 0) begin
        result_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    stat_t exp_r, got;
    if (!rst && result_valid && !result_stall) begin
      got = '{status, entry_valid, key_addr_a, key_addr_b, key_port_a, key_port_b,
              key_is_udp, tx_packets, rx_packets, tx_bytes, rx_bytes};
      if (expected_stats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: status %0d", status);
      end else begin
        exp_r = expected_stats.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p\n          actual   %p", exp_r, got);
        end
      end
    end
  end

  // Cycle counter: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 20000000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    mac_fill = 0; ip_fill = 0; flow_fill = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(500);
    test_streaming(150);
    test_table_full();
    test_random_traffic(60);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
